// ----- rtl/core/mi3_pkg.sv -----
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared constants for the 3x3 fixed-point matrix inverse pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package mi3_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int N_ENTRIES      = 9;

  // Stages ahead of the divider: input, products, cofactors, determinant
  // partial products, determinant, magnitudes, numerator setup.
  localparam int PRE_STAGES = 7;

endpackage

`default_nettype wire

// ----- rtl/core/matrix3_inverse.sv -----
// ----------------------------------------------------------------------------
// matrix3_inverse
// Inverse of a 3x3 signed fixed-point matrix through adjugate and determinant.
// ----------------------------------------------------------------------------
// One matrix beat enters per cycle and one result beat leaves per cycle while
// the output does not stall; the divider resolves one quotient bit per stage
// for all nine entries side by side. Each stage holds its beat until the next
// one frees up, so a stall at the output fills the pipeline before in_ready
// drops. Results are rounded to nearest with halves away from zero and
// saturated; a zero determinant gives all-zero entries with singular set.
`default_nettype none

module matrix3_inverse
  import mi3_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [DATA_WIDTH-1:0] m_r0c0,
  input  wire logic signed [DATA_WIDTH-1:0] m_r0c1,
  input  wire logic signed [DATA_WIDTH-1:0] m_r0c2,
  input  wire logic signed [DATA_WIDTH-1:0] m_r1c0,
  input  wire logic signed [DATA_WIDTH-1:0] m_r1c1,
  input  wire logic signed [DATA_WIDTH-1:0] m_r1c2,
  input  wire logic signed [DATA_WIDTH-1:0] m_r2c0,
  input  wire logic signed [DATA_WIDTH-1:0] m_r2c1,
  input  wire logic signed [DATA_WIDTH-1:0] m_r2c2,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0]      inv_r0c0,
  output logic signed [DATA_WIDTH-1:0]      inv_r0c1,
  output logic signed [DATA_WIDTH-1:0]      inv_r0c2,
  output logic signed [DATA_WIDTH-1:0]      inv_r1c0,
  output logic signed [DATA_WIDTH-1:0]      inv_r1c1,
  output logic signed [DATA_WIDTH-1:0]      inv_r1c2,
  output logic signed [DATA_WIDTH-1:0]      inv_r2c0,
  output logic signed [DATA_WIDTH-1:0]      inv_r2c1,
  output logic signed [DATA_WIDTH-1:0]      inv_r2c2,
  output logic                              singular,
  output logic                              overflow
);

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int CW   = 2 * W + 1;
  localparam int CMW  = 2 * W;
  localparam int DW   = 3 * W + 1;
  localparam int AW   = 3 * W;
  localparam int DNW  = 3 * W + 1;
  localparam int NA   = 2 * W + 2 * F + 1;
  localparam int NW   = ((NA > AW) ? NA : AW) + 1;
  localparam int NS   = PRE_STAGES + W + 2;
  localparam int LAST = NS - 1;

  localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  // Stage valid bits and the ready chain.
  logic [NS-1:0] v;
  logic [NS-1:0] rdy;

  assign rdy[LAST] = !v[LAST] || out_ready;
  for (genvar k = 0; k < LAST; k++) begin : g_rdy
    assign rdy[k] = !v[k] || rdy[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[LAST];

  logic signed [W-1:0] m_in [0:8];
  assign m_in[0] = m_r0c0;
  assign m_in[1] = m_r0c1;
  assign m_in[2] = m_r0c2;
  assign m_in[3] = m_r1c0;
  assign m_in[4] = m_r1c1;
  assign m_in[5] = m_r1c2;
  assign m_in[6] = m_r2c0;
  assign m_in[7] = m_r2c1;
  assign m_in[8] = m_r2c2;

  logic signed [W-1:0]     m0    [0:8];
  logic signed [2*W-1:0]   pa1   [0:8];
  logic signed [2*W-1:0]   pb1   [0:8];
  logic signed [W-1:0]     r0_1  [0:2];
  logic signed [CW-1:0]    cof2  [0:8];
  logic signed [W-1:0]     r0_2  [0:2];
  logic signed [2*W:0]     dlo3  [0:2];
  logic signed [2*W:0]     dhi3  [0:2];
  logic signed [CW-1:0]    cof3  [0:8];
  logic signed [DW-1:0]    det4;
  logic signed [CW-1:0]    cof4  [0:8];
  logic [AW-1:0]           absd5;
  logic                    zero5;
  logic                    dneg5;
  logic [CMW-1:0]          absc5 [0:8];
  logic                    cneg5 [0:8];
  logic [NW-1:0]           num6  [0:8];
  logic [DNW-1:0]          den6;
  logic                    neg6  [0:8];
  logic                    sing6;
  logic                    sing_d [0:W];
  logic [W-1:0]            q_d   [0:8];
  logic                    pov_d [0:8];
  logic                    ng_d  [0:8];
  logic signed [W-1:0]     res   [0:8];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int e = 0; e < N_ENTRIES; e++) begin
        m0[e] <= m_in[e];
      end
    end
  end

  // Cofactor products: C[r][c] = m[r1][c1]*m[r2][c2] - m[r1][c2]*m[r2][c1].
  for (genvar e = 0; e < N_ENTRIES; e++) begin : g_cof
    localparam int R  = e / 3;
    localparam int C  = e % 3;
    localparam int R1 = (R + 1) % 3;
    localparam int R2 = (R + 2) % 3;
    localparam int C1 = (C + 1) % 3;
    localparam int C2 = (C + 2) % 3;

    always_ff @(posedge clk) begin
      if (rdy[1]) begin
        pa1[e] <= m0[R1*3+C1] * m0[R2*3+C2];
        pb1[e] <= m0[R1*3+C2] * m0[R2*3+C1];
      end
      if (rdy[2]) begin
        cof2[e] <= CW'(pa1[e]) - CW'(pb1[e]);
      end
      if (rdy[3]) begin
        cof3[e] <= cof2[e];
      end
      if (rdy[4]) begin
        cof4[e] <= cof3[e];
      end
      if (rdy[5]) begin
        absc5[e] <= cof4[e][CW-1] ? CMW'(-cof4[e]) : CMW'(cof4[e]);
        cneg5[e] <= cof4[e][CW-1];
      end
      if (rdy[6]) begin
        num6[e] <= (NW'(absc5[e]) << (2 * F + 1)) + NW'(absd5);
        neg6[e] <= cneg5[e] ^ dneg5;
      end
    end
  end

  // Determinant along row 0, each cofactor split at W bits so that every
  // multiplier stays near W by W.
  for (genvar c = 0; c < 3; c++) begin : g_det
    always_ff @(posedge clk) begin
      if (rdy[1]) begin
        r0_1[c] <= m0[c];
      end
      if (rdy[2]) begin
        r0_2[c] <= r0_1[c];
      end
      if (rdy[3]) begin
        dlo3[c] <= r0_2[c] * $signed({1'b0, cof2[c][W-1:0]});
        dhi3[c] <= r0_2[c] * $signed(cof2[c][CW-1:W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      det4 <= DW'(dlo3[0]) + DW'(dlo3[1]) + DW'(dlo3[2])
            + ((DW'(dhi3[0]) + DW'(dhi3[1]) + DW'(dhi3[2])) <<< W);
    end
    if (rdy[5]) begin
      absd5 <= det4[DW-1] ? AW'(-det4) : AW'(det4);
      dneg5 <= det4[DW-1];
      zero5 <= (det4 == '0);
    end
    if (rdy[6]) begin
      den6  <= {absd5, 1'b0};
      sing6 <= zero5;
    end
  end

  // Singular flag rides alongside the divider stages.
  always_ff @(posedge clk) begin
    if (rdy[PRE_STAGES]) begin
      sing_d[0] <= sing6;
    end
    for (int k = 1; k <= W; k++) begin
      if (rdy[PRE_STAGES+k]) begin
        sing_d[k] <= sing_d[k-1];
      end
    end
  end

  logic [N_ENTRIES-1:0] sat;

  for (genvar e = 0; e < N_ENTRIES; e++) begin : g_div
    // Entry e of the inverse at row e/3, column e%3 is the cofactor at the
    // transposed position, so the divider for it is fed from that cofactor.
    localparam int SRC = (e % 3) * 3 + (e / 3);
    logic [W-1:0] lim;

    mi3_div #(
      .DATA_WIDTH (W),
      .NUM_WIDTH  (NW),
      .DEN_WIDTH  (DNW)
    ) u_div (
      .clk     (clk),
      .en      (rdy[PRE_STAGES +: W+1]),
      .num     (num6[SRC]),
      .den     (den6),
      .neg_in  (neg6[SRC]),
      .q       (q_d[e]),
      .pre_ovf (pov_d[e]),
      .neg_out (ng_d[e])
    );

    assign lim    = ng_d[e] ? HALF : HALF - 1'b1;
    assign sat[e] = pov_d[e] || (q_d[e] > lim);

    always_ff @(posedge clk) begin
      if (rdy[LAST]) begin
        if (sing_d[W]) begin
          res[e] <= '0;
        end else if (sat[e]) begin
          res[e] <= ng_d[e] ? MINV : MAXV;
        end else begin
          res[e] <= ng_d[e] ? -$signed(q_d[e]) : $signed(q_d[e]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[LAST]) begin
      singular <= sing_d[W];
      overflow <= !sing_d[W] && (|sat);
    end
  end

  assign inv_r0c0 = res[0];
  assign inv_r0c1 = res[1];
  assign inv_r0c2 = res[2];
  assign inv_r1c0 = res[3];
  assign inv_r1c1 = res[4];
  assign inv_r1c2 = res[5];
  assign inv_r2c0 = res[6];
  assign inv_r2c1 = res[7];
  assign inv_r2c2 = res[8];

  // A singular beat never reports overflow and carries zero entries (checked on the diagonal, r0c1 and r2c0).
  a_sing_no_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> !overflow)
    else $error("singular result flagged overflow");

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> (inv_r0c0 == '0) && (inv_r1c1 == '0) && (inv_r2c2 == '0)
      && (inv_r0c1 == '0) && (inv_r2c0 == '0))
    else $error("singular result has nonzero entries");

  // Back-pressure reaches the input only once every stage holds a beat.
  a_full_before_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&v))
    else $error("input stalled with an empty stage");

  // Overflow means at least one entry sits at a saturation bound.
  a_ovf_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |->
      (inv_r0c0 == MAXV) || (inv_r0c0 == MINV) || (inv_r0c1 == MAXV) || (inv_r0c1 == MINV)
      || (inv_r0c2 == MAXV) || (inv_r0c2 == MINV) || (inv_r1c0 == MAXV) || (inv_r1c0 == MINV)
      || (inv_r1c1 == MAXV) || (inv_r1c1 == MINV) || (inv_r1c2 == MAXV) || (inv_r1c2 == MINV)
      || (inv_r2c0 == MAXV) || (inv_r2c0 == MINV) || (inv_r2c1 == MAXV) || (inv_r2c1 == MINV)
      || (inv_r2c2 == MAXV) || (inv_r2c2 == MINV))
    else $error("overflow without a saturated entry");

endmodule

`default_nettype wire

// ----- rtl/core/mi3_div.sv -----
// ----------------------------------------------------------------------------
// mi3_div
// Pipelined restoring divider, one quotient bit per stage. The first stage
// flags quotients that do not fit in DATA_WIDTH bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_div
  import mi3_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int NUM_WIDTH  = 98,
  parameter int DEN_WIDTH  = 97
) (
  input  wire logic                  clk,
  input  wire logic [DATA_WIDTH:0]   en,
  input  wire logic [NUM_WIDTH-1:0]  num,
  input  wire logic [DEN_WIDTH-1:0]  den,
  input  wire logic                  neg_in,
  output logic      [DATA_WIDTH-1:0] q,
  output logic                       pre_ovf,
  output logic                       neg_out
);

  localparam int W    = DATA_WIDTH;
  localparam int HW   = NUM_WIDTH - W;
  localparam int CMPW = (HW > DEN_WIDTH) ? HW : DEN_WIDTH;

  logic [DEN_WIDTH-1:0] rem [0:W];
  logic [W-1:0]         lo  [0:W];
  logic [W-1:0]         qv  [0:W];
  logic [DEN_WIDTH-1:0] dv  [0:W];
  logic                 ov  [0:W];
  logic                 ng  [0:W];

  logic [CMPW-1:0] hi_ext;
  logic [CMPW-1:0] den_ext;

  assign hi_ext  = CMPW'(num[NUM_WIDTH-1:W]);
  assign den_ext = CMPW'(den);

  // The top bits of the numerator must stay below the divisor, or the
  // quotient has more than DATA_WIDTH bits.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0] <= hi_ext[DEN_WIDTH-1:0];
      lo[0]  <= num[W-1:0];
      qv[0]  <= '0;
      dv[0]  <= den;
      ov[0]  <= (hi_ext >= den_ext);
      ng[0]  <= neg_in;
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_step
    logic [DEN_WIDTH:0] rsh;
    logic [DEN_WIDTH:0] diff;
    logic               ge;

    assign rsh  = {rem[k-1], lo[k-1][W-1]};
    assign ge   = (rsh >= {1'b0, dv[k-1]});
    assign diff = rsh - {1'b0, dv[k-1]};

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem[k] <= ge ? diff[DEN_WIDTH-1:0] : rsh[DEN_WIDTH-1:0];
        lo[k]  <= {lo[k-1][W-2:0], 1'b0};
        qv[k]  <= {qv[k-1][W-2:0], ge};
        dv[k]  <= dv[k-1];
        ov[k]  <= ov[k-1];
        ng[k]  <= ng[k-1];
      end
    end
  end

  assign q       = qv[W];
  assign pre_ovf = ov[W];
  assign neg_out = ng[W];

endmodule

`default_nettype wire

// ----- verif/matrix3_inverse_checker.sv -----
// ----------------------------------------------------------------------------
// matrix3_inverse_checker
// Watches both channels of the matrix inverse, predicts each result from the
// accepted matrix with exact wide arithmetic, and compares field by field.
// ----------------------------------------------------------------------------
module matrix3_inverse_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] m_in [9],
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] inv_out [9],
  input  logic               singular,
  input  logic               overflow,
  output int                 fail_count,
  output int                 pending_count,
  output int                 result_count,
  output int                 singular_count,
  output int                 overflow_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [8:0][31:0] entry;
    logic             sing;
    logic             ovf;
  } inverse_t;

  inverse_t inverse_q[$];

  // Rounded, saturated cof * 2^32 / det, halves away from zero.
  function automatic logic [31:0] scaled_quotient(input logic signed [127:0] cof,
                                                  input logic signed [127:0] det,
                                                  inout logic ovf);
    logic         neg;
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] q;
    logic [127:0] lim;
    neg = cof[127] ^ det[127];
    num = cof[127] ? -cof : cof;
    den = det[127] ? -det : det;
    q = ((num << 33) + den) / (den << 1);
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) begin
      q = lim;
      ovf = 1'b1;
    end
    return neg ? 32'(-q) : q[31:0];
  endfunction

  function automatic inverse_t invert(input logic signed [31:0] m [9]);
    logic signed [127:0] a [3][3];
    logic signed [127:0] cof [3][3];
    logic signed [127:0] det;
    inverse_t res;
    logic ovf;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) a[r][c] = m[r*3+c];
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        cof[r][c] = a[(r+1)%3][(c+1)%3] * a[(r+2)%3][(c+2)%3]
                  - a[(r+1)%3][(c+2)%3] * a[(r+2)%3][(c+1)%3];
    det = a[0][0]*cof[0][0] + a[0][1]*cof[0][1] + a[0][2]*cof[0][2];
    res = '0;
    ovf = 1'b0;
    if (det == 0) begin
      res.sing = 1'b1;
      return res;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        res.entry[r*3+c] = scaled_quotient(cof[c][r], det, ovf);
    res.ovf = ovf;
    return res;
  endfunction

  assign pending_count = inverse_q.size();

  always @(posedge clk) begin
    inverse_t want;
    logic     bad;
    if (rst) begin
      fail_count <= 0;
      result_count <= 0;
      singular_count <= 0;
      overflow_count <= 0;
    end else begin
      if (in_valid && in_ready) inverse_q.push_back(invert(m_in));
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        singular_count <= singular_count + singular;
        overflow_count <= overflow_count + overflow;
        if (inverse_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat at %0t", $realtime);
          fail_count <= fail_count + 1;
        end else begin
          want = inverse_q.pop_front();
          bad = (want.sing !== singular) || (want.ovf !== overflow);
          for (int i = 0; i < 9; i++) bad |= (want.entry[i] !== inv_out[i]);
          if (bad) begin
            if (fail_count < 10) begin
              $display("mismatch at %0t: sing %b/%b ovf %b/%b", $realtime,
                       want.sing, singular, want.ovf, overflow);
              for (int i = 0; i < 9; i++)
                $display("  entry %0d expected %h got %h", i, want.entry[i], inv_out[i]);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ----- verif/tb_matrix3_inverse.sv -----
// ----------------------------------------------------------------------------
// tb_matrix3_inverse
// Drives directed and random matrices into the 3x3 inverse with random gaps
// on both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_matrix3_inverse;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE = 32'h0001_0000;
  localparam int CYCLE_LIMIT = 400000;

  logic clk, rst, in_valid, in_ready, out_valid, out_ready, singular, overflow;
  logic signed [31:0] m [9];
  logic signed [31:0] inv [9];
  int fail_count, pending_count, result_count, singular_count, overflow_count;
  int cycles;

  matrix3_inverse dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .m_r0c0(m[0]), .m_r0c1(m[1]), .m_r0c2(m[2]), .m_r1c0(m[3]), .m_r1c1(m[4]),
    .m_r1c2(m[5]), .m_r2c0(m[6]), .m_r2c1(m[7]), .m_r2c2(m[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .inv_r0c0(inv[0]), .inv_r0c1(inv[1]), .inv_r0c2(inv[2]), .inv_r1c0(inv[3]),
    .inv_r1c1(inv[4]), .inv_r1c2(inv[5]), .inv_r2c0(inv[6]), .inv_r2c1(inv[7]),
    .inv_r2c2(inv[8]), .singular(singular), .overflow(overflow)
  );

  matrix3_inverse_checker checker_i (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .m_in(m),
    .out_valid(out_valid), .out_ready(out_ready), .inv_out(inv),
    .singular(singular), .overflow(overflow), .fail_count(fail_count),
    .pending_count(pending_count), .result_count(result_count),
    .singular_count(singular_count), .overflow_count(overflow_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int gap_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
      3: return $signed($urandom_range(0, 64)) - 32;
      default: return $signed($urandom_range(0, 2 * ONE)) - ONE;
    endcase
  endfunction

  // The cycle counter also times out a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[matrix3_inverse] ERROR");
      $finish;
    end
  end

  // Output side stalls at random, with calm stretches.
  always @(posedge clk) begin
    int hold;
    if (rst) begin
      out_ready <= 1'b0;
      hold = 0;
    end else if (hold > 0) begin
      hold--;
      out_ready <= 1'b0;
    end else begin
      hold = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
      out_ready <= (hold == 0);
    end
  end

  // Valid drops only when a gap follows, so back-to-back beats keep it high.
  task automatic send_matrix(input logic [31:0] e [9]);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    for (int i = 0; i < 9; i++) m[i] <= e[i];
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    logic [31:0] e [9];
    int kind, settle;
    cycles = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    for (int i = 0; i < 9; i++) m[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: identity, scaled, zero, extremes, near-singular and saturating.
    for (int k = 0; k < 14; k++) begin
      for (int i = 0; i < 9; i++) e[i] = 0;
      case (k)
        0: begin e[0] = ONE; e[4] = ONE; e[8] = ONE; end
        1: begin e[0] = 2 * ONE; e[4] = -ONE; e[8] = ONE / 2; end
        2: ;
        3: for (int i = 0; i < 9; i++) e[i] = 32'h7FFF_FFFF;
        4: for (int i = 0; i < 9; i++) e[i] = 32'h8000_0000;
        5: begin e[0] = 32'h8000_0000; e[4] = 32'h8000_0000; e[8] = 32'h8000_0000; end
        6: begin e[0] = 32'h7FFF_FFFF; e[4] = 32'h8000_0000; e[8] = 32'h7FFF_FFFF; end
        7: begin e[0] = 1; e[4] = 1; e[8] = 1; end
        8: begin e[0] = -1; e[4] = 1; e[8] = 3; end
        9: begin e[0] = 3; e[4] = 3; e[8] = 3; e[1] = 32'hFFFF_FFFF; end
        10: begin e[0] = ONE; e[1] = 2 * ONE; e[3] = 2 * ONE; e[4] = 4 * ONE;
                  e[8] = ONE; end
        11: begin e[0] = 32'h7FFF_FFFF; e[4] = 32'h7FFF_FFFF; e[8] = 32'h7FFF_FFFF; end
        12: begin e[2] = ONE; e[4] = -ONE; e[6] = ONE; end
        13: for (int i = 0; i < 9; i++) e[i] = 32'h5555_5555 << (i & 1);
        default: ;
      endcase
      send_matrix(e);
    end

    // Random: full-range noise, small values, and singular matrices built
    // from a repeated row, a zero row or a negated column.
    for (int n = 0; n < 800; n++) begin
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) e[i] = rand_entry();
      if (kind == 0) for (int c = 0; c < 3; c++) e[6+c] = e[c];
      else if (kind == 1) for (int c = 0; c < 3; c++) e[3+c] = 0;
      else if (kind == 2) for (int r = 0; r < 3; r++) e[r*3+2] = -e[r*3];
      send_matrix(e);
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    settle = 0;
    while (settle < 100) begin
      @(posedge clk);
      settle++;
    end
    $display("Ran %0d matrices, %0d singular and %0d with saturation.",
             result_count, singular_count, overflow_count);
    if (fail_count == 0 && pending_count == 0) $display("[matrix3_inverse] OK");
    else $display("[matrix3_inverse] ERROR");
    $finish;
  end
endmodule
